FILE: rtl/rhssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhssm_pkg
// Types, codes and constants shared by the hot-swap M-state controller.
// ----------------------------------------------------------------------------
package rhssm_pkg;

  // Default number of blink ticks in one blue LED blink period.
  localparam int BLINK_PERIOD_DEF = 10;

  // Operation carried by one input beat.
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_POWER = 2'd1,
    OP_LED   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Hot-swap states.
  typedef enum logic [2:0] {
    M0 = 3'd0,
    M1 = 3'd1,
    M2 = 3'd2,
    M3 = 3'd3,
    M4 = 3'd4,
    M5 = 3'd5,
    M6 = 3'd6
  } mstate_t;

  // Event codes.
  typedef enum logic [2:0] {
    EV_ABSENT   = 3'd0,
    EV_PRESENT  = 3'd1,
    EV_COMPAT   = 3'd2,
    EV_INCOMPAT = 3'd3,
    EV_OPENED   = 3'd4,
    EV_CLOSED   = 3'd5,
    EV_QUIESCED = 3'd6
  } event_t;

  // LED command codes.
  localparam logic [1:0] LED_SEL_NONE = 2'd3;
  localparam logic [1:0] LED_MODE_OFF = 2'd0;
  localparam logic [1:0] LED_MODE_ON  = 2'd1;

  // Bit positions in the sensor flags.
  localparam int FLB_CLOSED  = 0;
  localparam int FLB_OPEN    = 1;
  localparam int FLB_QUIESC  = 2;
  localparam int FLB_PRESENT = 3;
  localparam int FLB_COMPAT  = 4;
  localparam int FLB_SCAN    = 5;

  // Bit positions in the LED, power and enable groups.
  localparam int LEDB_BLUE  = 0;
  localparam int PWRB_MGMT  = 0;
  localparam int PWRB_PAYLD = 1;
  localparam int ENB_SENS   = 0;
  localparam int ENB_HS     = 1;

  // One input beat.
  typedef struct packed {
    op_t        operation;
    logic       module_absent;
    logic       handle_open;
    logic       compat_ok;
    logic       carrier_active;
    logic       power_level;
    logic [1:0] led_select;
    logic [1:0] led_mode;
  } item_t;

  // Controller state, apart from the blink counter.
  typedef struct packed {
    mstate_t    mstate;
    logic       compat_done;
    logic       blink_on;
    logic [2:0] leds;
    logic [1:0] power;
    logic [5:0] flags;
    logic [1:0] enables;
  } ctl_state_t;

  // One result beat.
  typedef struct packed {
    mstate_t    m_state;
    logic       mgmt_power_on;
    logic       payload_power_on;
    logic       blue_led_on;
    logic       red_led_on;
    logic       green_led_on;
    logic       event_valid;
    event_t     event_code;
    logic [5:0] sensor_flags;
    logic       sensors_enabled;
    logic       hs_sensor_enabled;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/rtm_hot_swap_state_machine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_hot_swap_state_machine
// Hot-swap M-state controller for a rear transition module: polls, power
// commands, LED commands and blink ticks, one result beat per input beat.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake              Payload
//   in_       input       in_valid / in_stall    operation and sampled pins
//   out_      output      out_valid / out_stall  state, enables, LEDs, event
//
// One beat is accepted per cycle while in_stall is low. Its result is offered once
// the beat has moved from the input register into the result register, and is
// taken when out_stall is low.
// The controller state is updated when a beat moves from the input register
// into the result register, so beats are applied strictly in order.
// A stalled result holds the input register, which then stalls the input.
// Synchronous active-low reset puts the controller in M0 with no result pending.
// ----------------------------------------------------------------------------
module rtm_hot_swap_state_machine #(
  parameter int BLINK_PERIOD = rhssm_pkg::BLINK_PERIOD_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_operation,
  input  wire        in_module_absent,
  input  wire        in_handle_open,
  input  wire        in_compat_ok,
  input  wire        in_carrier_active,
  input  wire        in_power_level,
  input  wire  [1:0] in_led_select,
  input  wire  [1:0] in_led_mode,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] out_m_state,
  output logic       out_mgmt_power_on,
  output logic       out_payload_power_on,
  output logic       out_blue_led_on,
  output logic       out_red_led_on,
  output logic       out_green_led_on,
  output logic       out_event_valid,
  output logic [2:0] out_event_code,
  output logic [5:0] out_sensor_flags,
  output logic       out_sensors_enabled,
  output logic       out_hs_sensor_enabled
);

  localparam int CNT_W = $clog2(BLINK_PERIOD + 1);

  rhssm_pkg::item_t      item_r;
  logic                  item_valid_r;
  rhssm_pkg::ctl_state_t state_r;
  rhssm_pkg::ctl_state_t state_nxt;
  logic [CNT_W-1:0]      blink_cnt_r;
  logic [CNT_W-1:0]      blink_cnt_nxt;
  rhssm_pkg::result_t    result_r;
  rhssm_pkg::result_t    result_nxt;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  step_fire;
  logic                  in_accept;

  // Handshake: the result slot is free when empty or being taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign step_fire = item_valid_r && out_free;
  assign in_stall  = item_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_accept) begin
      item_valid_r <= 1'b1;
    end else if (step_fire) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.operation      <= rhssm_pkg::op_t'(in_operation);
      item_r.module_absent  <= in_module_absent;
      item_r.handle_open    <= in_handle_open;
      item_r.compat_ok      <= in_compat_ok;
      item_r.carrier_active <= in_carrier_active;
      item_r.power_level    <= in_power_level;
      item_r.led_select     <= in_led_select;
      item_r.led_mode       <= in_led_mode;
    end
  end

  // Step logic between the input register and the result register.
  rhssm_step #(
    .BLINK_PERIOD (BLINK_PERIOD),
    .CNT_W        (CNT_W)
  ) u_step (
    .item          (item_r),
    .st            (state_r),
    .blink_cnt     (blink_cnt_r),
    .st_nxt        (state_nxt),
    .blink_cnt_nxt (blink_cnt_nxt),
    .res           (result_nxt)
  );

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mstate      <= rhssm_pkg::M0;
      state_r.compat_done <= 1'b0;
      state_r.blink_on    <= 1'b0;
      state_r.leds        <= '0;
      state_r.power       <= '0;
      state_r.flags       <= '0;
      state_r.enables     <= '0;
      blink_cnt_r         <= CNT_W'(BLINK_PERIOD);
    end else if (step_fire) begin
      state_r     <= state_nxt;
      blink_cnt_r <= blink_cnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result_r <= result_nxt;
    end
  end

  // Output ports.
  assign out_valid             = out_valid_r;
  assign out_m_state           = result_r.m_state;
  assign out_mgmt_power_on     = result_r.mgmt_power_on;
  assign out_payload_power_on  = result_r.payload_power_on;
  assign out_blue_led_on       = result_r.blue_led_on;
  assign out_red_led_on        = result_r.red_led_on;
  assign out_green_led_on      = result_r.green_led_on;
  assign out_event_valid       = result_r.event_valid;
  assign out_event_code        = result_r.event_code;
  assign out_sensor_flags      = result_r.sensor_flags;
  assign out_sensors_enabled   = result_r.sensors_enabled;
  assign out_hs_sensor_enabled = result_r.hs_sensor_enabled;

`ifndef NO_ASSERTIONS
  // The input only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while the result slot was free");

  // The controller state only moves when a beat is stepped.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_fire |=> $stable(state_r) && $stable(blink_cnt_r))
    else $error("controller state changed without a beat");

  // The reported state is the state that the beat left behind.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> (result_r.m_state == state_r.mstate))
    else $error("result state differs from controller state");

  // The handle is never reported closed and open at once.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.flags[rhssm_pkg::FLB_CLOSED] && state_r.flags[rhssm_pkg::FLB_OPEN]))
    else $error("handle flags closed and open both set");

  // The blink counter stays within one period.
  a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
    blink_cnt_r <= CNT_W'(BLINK_PERIOD))
    else $error("blink counter beyond its period");
`endif

endmodule
`default_nettype wire

FILE: rtl/rhssm_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhssm_step
// Combinational step logic: applies one operation to the controller state and
// forms the result beat from the updated state.
// ----------------------------------------------------------------------------
module rhssm_step #(
  parameter int BLINK_PERIOD = rhssm_pkg::BLINK_PERIOD_DEF,
  parameter int CNT_W        = $clog2(BLINK_PERIOD + 1)
) (
  input  var rhssm_pkg::item_t      item,
  input  var rhssm_pkg::ctl_state_t st,
  input  wire [CNT_W-1:0]           blink_cnt,
  output rhssm_pkg::ctl_state_t     st_nxt,
  output logic [CNT_W-1:0]          blink_cnt_nxt,
  output rhssm_pkg::result_t        res
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLINK_PERIOD);
  localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(BLINK_PERIOD / 2);

  rhssm_pkg::mstate_t mstate_nxt;
  logic               ev_valid;
  rhssm_pkg::event_t  ev_code;
  logic [CNT_W-1:0]   cnt_load;

  // Next hot-swap state.
  always_comb begin
    mstate_nxt = st.mstate;
    case (item.operation)
      rhssm_pkg::OP_POLL: begin
        if (item.module_absent) begin
          mstate_nxt = rhssm_pkg::M0;
        end else begin
          case (st.mstate)
            rhssm_pkg::M0: mstate_nxt = rhssm_pkg::M1;
            rhssm_pkg::M1: begin
              if (st.compat_done && item.carrier_active &&
                  st.flags[rhssm_pkg::FLB_COMPAT] && !item.handle_open) begin
                mstate_nxt = rhssm_pkg::M2;
              end
            end
            rhssm_pkg::M2: mstate_nxt = rhssm_pkg::M3;
            rhssm_pkg::M3: if (item.handle_open) mstate_nxt = rhssm_pkg::M6;
            rhssm_pkg::M4: if (item.handle_open) mstate_nxt = rhssm_pkg::M5;
            rhssm_pkg::M5: if (!item.handle_open) mstate_nxt = rhssm_pkg::M4;
            default: mstate_nxt = st.mstate;
          endcase
        end
      end
      rhssm_pkg::OP_POWER: begin
        mstate_nxt = item.power_level ? rhssm_pkg::M4 : rhssm_pkg::M1;
      end
      default: mstate_nxt = st.mstate;
    endcase
  end

  // Power, LEDs, flags, enables, blink counter and the event of this beat.
  always_comb begin
    st_nxt        = st;
    blink_cnt_nxt = blink_cnt;
    ev_valid      = 1'b0;
    ev_code       = rhssm_pkg::EV_ABSENT;
    cnt_load      = (blink_cnt == '0) ? CNT_FULL : blink_cnt;
    case (item.operation)
      rhssm_pkg::OP_POLL: begin
        if (item.module_absent) begin
          // A module pulled out above M0 drops power and reports it.
          if (st.mstate != rhssm_pkg::M0) begin
            st_nxt.enables = '0;
            st_nxt.power   = '0;
            ev_valid       = 1'b1;
            ev_code        = rhssm_pkg::EV_ABSENT;
            st_nxt.flags   = '0;
          end else begin
            st_nxt.flags = st.flags & (6'b1 << rhssm_pkg::FLB_SCAN);
          end
        end else begin
          case (st.mstate)
            rhssm_pkg::M0: begin
              st_nxt.power[rhssm_pkg::PWRB_MGMT] = 1'b1;
              st_nxt.leds[rhssm_pkg::LEDB_BLUE]  = 1'b1;
              st_nxt.blink_on                     = 1'b0;
              st_nxt.enables[rhssm_pkg::ENB_HS]   = 1'b1;
              st_nxt.flags = st.flags & (6'b1 << rhssm_pkg::FLB_SCAN);
              st_nxt.flags[rhssm_pkg::FLB_PRESENT] = 1'b1;
              st_nxt.flags[rhssm_pkg::FLB_OPEN]    = 1'b1;
              ev_valid           = 1'b1;
              ev_code            = rhssm_pkg::EV_PRESENT;
              st_nxt.compat_done = 1'b0;
            end
            rhssm_pkg::M1: begin
              if (!st.compat_done) begin
                // The compatibility result is taken once.
                st_nxt.flags[rhssm_pkg::FLB_COMPAT] = item.compat_ok;
                if (item.compat_ok) begin
                  st_nxt.enables[rhssm_pkg::ENB_SENS] = 1'b1;
                end
                ev_valid           = 1'b1;
                ev_code            = item.compat_ok ? rhssm_pkg::EV_COMPAT
                                                    : rhssm_pkg::EV_INCOMPAT;
                st_nxt.compat_done = 1'b1;
              end else if (item.carrier_active && st.flags[rhssm_pkg::FLB_COMPAT] &&
                           !item.handle_open) begin
                ev_valid = 1'b1;
                ev_code  = rhssm_pkg::EV_CLOSED;
                st_nxt.flags[rhssm_pkg::FLB_OPEN]   = 1'b0;
                st_nxt.flags[rhssm_pkg::FLB_CLOSED] = 1'b1;
              end
            end
            rhssm_pkg::M2: begin
              st_nxt.flags[rhssm_pkg::FLB_SCAN] = 1'b1;
            end
            rhssm_pkg::M3, rhssm_pkg::M4: begin
              if (item.handle_open) begin
                ev_valid = 1'b1;
                ev_code  = rhssm_pkg::EV_OPENED;
                st_nxt.flags[rhssm_pkg::FLB_CLOSED] = 1'b0;
                st_nxt.flags[rhssm_pkg::FLB_OPEN]   = 1'b1;
              end
            end
            rhssm_pkg::M5: begin
              if (!item.handle_open) begin
                ev_valid = 1'b1;
                ev_code  = rhssm_pkg::EV_CLOSED;
                st_nxt.flags[rhssm_pkg::FLB_OPEN]   = 1'b0;
                st_nxt.flags[rhssm_pkg::FLB_CLOSED] = 1'b1;
              end
            end
            rhssm_pkg::M6: begin
              // Quiesced is reported again on every poll while the module is present.
              st_nxt.flags[rhssm_pkg::FLB_QUIESC] = 1'b1;
              st_nxt.flags[rhssm_pkg::FLB_OPEN]   = 1'b0;
              st_nxt.flags[rhssm_pkg::FLB_CLOSED] = 1'b0;
              ev_valid = 1'b1;
              ev_code  = rhssm_pkg::EV_QUIESCED;
            end
            default: st_nxt = st;
          endcase
        end
      end
      rhssm_pkg::OP_POWER: begin
        st_nxt.power[rhssm_pkg::PWRB_PAYLD] = item.power_level;
      end
      rhssm_pkg::OP_LED: begin
        if (item.led_select != rhssm_pkg::LED_SEL_NONE) begin
          if (item.led_mode == rhssm_pkg::LED_MODE_OFF ||
              item.led_mode == rhssm_pkg::LED_MODE_ON) begin
            st_nxt.leds[item.led_select] = (item.led_mode == rhssm_pkg::LED_MODE_ON);
            st_nxt.blink_on              = 1'b0;
          end else begin
            // Any blink request blinks the blue LED.
            st_nxt.blink_on = 1'b1;
          end
        end
      end
      rhssm_pkg::OP_TICK: begin
        if (st.blink_on) begin
          if (cnt_load == CNT_FULL) begin
            st_nxt.leds[rhssm_pkg::LEDB_BLUE] = 1'b1;
          end
          if (cnt_load == CNT_HALF) begin
            st_nxt.leds[rhssm_pkg::LEDB_BLUE] = 1'b0;
          end
          blink_cnt_nxt = cnt_load - CNT_W'(1);
        end
      end
      default: st_nxt = st;
    endcase
    st_nxt.mstate = mstate_nxt;
  end

  // Result beat from the updated state.
  always_comb begin
    res.m_state           = st_nxt.mstate;
    res.mgmt_power_on     = st_nxt.power[rhssm_pkg::PWRB_MGMT];
    res.payload_power_on  = st_nxt.power[rhssm_pkg::PWRB_PAYLD];
    res.blue_led_on       = st_nxt.leds[0];
    res.red_led_on        = st_nxt.leds[1];
    res.green_led_on      = st_nxt.leds[2];
    res.event_valid       = ev_valid;
    res.event_code        = ev_code;
    res.sensor_flags      = st_nxt.flags;
    res.sensors_enabled   = st_nxt.enables[rhssm_pkg::ENB_SENS];
    res.hs_sensor_enabled = st_nxt.enables[rhssm_pkg::ENB_HS];
  end

endmodule
`default_nettype wire
